// ----- hdl/csu_pkg.sv -----
// Shared types and constants for the text buffer with erase stack and undo journal.
package csu_pkg;

	localparam int TEXT_DEPTH    = 4096;
	localparam int ERASED_DEPTH  = 4096;
	localparam int JOURNAL_DEPTH = 1024;

	localparam int TA_W = $clog2(TEXT_DEPTH);
	localparam int EA_W = $clog2(ERASED_DEPTH);
	localparam int JA_W = $clog2(JOURNAL_DEPTH);
	localparam int TL_W = TA_W + 1;
	localparam int EL_W = EA_W + 1;
	localparam int JL_W = JA_W + 1;
	localparam int CNT_W = 13;
	localparam int LEN_W = (TL_W > EL_W) ? TL_W : EL_W;
	localparam int JE_W  = LEN_W + 1;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_ERASE  = 2'd1,
		OP_READ   = 2'd2,
		OP_UNDO   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_BAD   = 3'd1,
		ST_EMPTY = 3'd2,
		ST_FULL  = 3'd3,
		ST_OPEN  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [7:0]       data_byte;
		logic             run_end;
		logic [CNT_W-1:0] count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       read_byte;
		logic [CNT_W-1:0] text_length;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [7:0]       data_byte;
		logic             run_end;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_MOVE,
		BK_JRD,
		BK_DONE
	} bk_state_t;

endpackage

// ----- hdl/csu_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module csu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/csu_front.sv -----
// Front end: accept items into a two-entry command queue.
module csu_front import csu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t in_item,
	input  logic     push,
	output logic     full,
	output cmd_t     cmd,
	output logic     cmd_valid,
	input  logic     cmd_take
);
	cmd_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= cmd_t'(in_item);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule

// ----- hdl/csu_back.sv -----
// Back end: execute commands against the text, erased stack and journal memories.
module csu_back import csu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_take,
	output out_item_t res,
	output logic      res_valid,
	input  logic      res_take
);
	bk_state_t state_q, state_d;
	logic [TL_W-1:0] text_len_q;
	logic [EL_W-1:0] erased_len_q;
	logic [JL_W-1:0] journal_len_q;
	logic [TL_W-1:0] run_len_q;
	logic [LEN_W-1:0] left_q;
	logic            dir_q;      // 1: text -> erased, 0: erased -> text
	logic            first_q;
	logic [TL_W-1:0] src_q;
	logic [TL_W-1:0] dst_q;
	out_item_t       res_q;
	logic            res_v_q;

	logic            t_we, e_we, j_we;
	logic [TA_W-1:0] t_waddr, t_raddr;
	logic [EA_W-1:0] e_waddr, e_raddr;
	logic [JA_W-1:0] j_waddr, j_raddr;
	logic [7:0]      t_wdata, t_rdata, e_rdata;
	logic [JE_W-1:0] j_wdata, j_rdata;

	csu_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
		.clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata));
	csu_ram #(.WIDTH(8), .DEPTH(ERASED_DEPTH)) u_erased (
		.clk, .we(e_we), .waddr(e_waddr), .wdata(t_rdata), .raddr(e_raddr), .rdata(e_rdata));
	csu_ram #(.WIDTH(JE_W), .DEPTH(JOURNAL_DEPTH)) u_jrnl (
		.clk, .we(j_we), .waddr(j_waddr), .wdata(j_wdata), .raddr(j_raddr), .rdata(j_rdata));

	logic start;
	assign cmd_take  = (state_q == BK_IDLE) && cmd_valid && !res_v_q;
	assign start     = cmd_take;
	assign res       = res_q;
	assign res_valid = res_v_q;

	logic [CNT_W-1:0] cnt_ext;
	logic             jfull, cnt_bad, e_room;
	logic [EL_W:0]    e_free;
	assign cnt_ext = cmd.count;
	assign jfull   = (journal_len_q >= JL_W'(JOURNAL_DEPTH));
	assign cnt_bad = (cnt_ext == '0) || ({1'b0, cnt_ext} > (CNT_W+1)'(text_len_q));
	assign e_free  = (EL_W+1)'(ERASED_DEPTH) - (EL_W+1)'(erased_len_q);
	assign e_room  = (CNT_W+1)'(cnt_ext) <= (CNT_W+1)'(e_free);

	// undo of an erase: clipped amount
	logic [LEN_W-1:0] un_n, un_n1;
	logic [TL_W:0]    t_free;
	assign t_free = (TL_W+1)'(TEXT_DEPTH) - (TL_W+1)'(text_len_q);
	always_comb begin
		un_n1 = j_rdata[LEN_W-1:0];
		if (un_n1 > LEN_W'(erased_len_q)) un_n1 = LEN_W'(erased_len_q);
		un_n = un_n1;
		if ((TL_W+1)'(un_n1) > t_free) un_n = LEN_W'(t_free);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (start) begin
					if (cmd.opcode == OP_APPEND || run_len_q != '0) state_d = BK_DONE;
					else if (cmd.opcode == OP_ERASE)
						state_d = (cnt_bad || !e_room || jfull) ? BK_DONE : BK_MOVE;
					else if (cmd.opcode == OP_READ)
						state_d = cnt_bad ? BK_DONE : BK_READ;
					else
						state_d = (journal_len_q == '0) ? BK_DONE : BK_JRD;
				end
			end
			BK_READ: state_d = BK_DONE;
			BK_JRD: begin
				if (j_rdata[JE_W-1] && un_n != '0) state_d = BK_MOVE;
				else state_d = BK_DONE;
			end
			BK_MOVE: if (left_q == '0) state_d = BK_DONE;
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		t_we = 1'b0; e_we = 1'b0; j_we = 1'b0;
		t_waddr = dst_q[TA_W-1:0]; t_wdata = e_rdata;
		e_waddr = dst_q[EA_W-1:0];
		t_raddr = src_q[TA_W-1:0];
		e_raddr = src_q[EA_W-1:0];
		j_raddr = JA_W'(journal_len_q - JL_W'(1));
		j_waddr = journal_len_q[JA_W-1:0];
		j_wdata = '0;
		if (state_q == BK_IDLE && start && cmd.opcode == OP_READ)
			t_raddr = TA_W'(cnt_ext - CNT_W'(1));
		if (state_q == BK_IDLE && start && cmd.opcode == OP_APPEND) begin
			t_waddr = text_len_q[TA_W-1:0];
			t_wdata = cmd.data_byte;
			t_we = !(run_len_q == '0 && jfull) && (text_len_q < TL_W'(TEXT_DEPTH));
			j_wdata = {1'b0, LEN_W'(run_len_q + TL_W'(t_we))};
			j_we = !(run_len_q == '0 && jfull) && cmd.run_end && (run_len_q != '0 || t_we);
		end
		if (state_q == BK_IDLE && start && cmd.opcode == OP_ERASE && run_len_q == '0) begin
			j_wdata = {1'b1, LEN_W'(cnt_ext)};
			j_we = !cnt_bad && e_room && !jfull;
		end
		if (state_q == BK_MOVE && !first_q) begin
			if (dir_q) e_we = 1'b1;
			else t_we = 1'b1;
		end
	end

	// status of the command being taken
	status_t st_d;
	always_comb begin
		st_d = ST_OK;
		if (cmd.opcode == OP_APPEND) begin
			if ((run_len_q == '0 && jfull) || !t_we) st_d = ST_FULL;
		end else if (run_len_q != '0) st_d = ST_OPEN;
		else if (cmd.opcode == OP_ERASE) begin
			if (cnt_bad) st_d = ST_BAD;
			else if (!e_room || jfull) st_d = ST_FULL;
		end else if (cmd.opcode == OP_READ) begin
			if (cnt_bad) st_d = ST_BAD;
		end else if (journal_len_q == '0) st_d = ST_EMPTY;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			text_len_q <= '0; erased_len_q <= '0; journal_len_q <= '0; run_len_q <= '0;
			left_q <= '0; dir_q <= 1'b0; first_q <= 1'b0; src_q <= '0; dst_q <= '0;
			res_q <= '0; res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_v_q && res_take) res_v_q <= 1'b0;
			case (state_q)
				BK_IDLE: begin
					if (start) begin
						res_q.read_byte <= '0;
						res_q.status <= st_d;
						if (cmd.opcode == OP_APPEND) begin
							if (t_we) text_len_q <= text_len_q + TL_W'(1);
							if (j_we) begin
								journal_len_q <= journal_len_q + JL_W'(1);
								run_len_q <= '0;
							end else if (t_we) run_len_q <= run_len_q + TL_W'(1);
						end else if (cmd.opcode == OP_ERASE && st_d == ST_OK) begin
							journal_len_q <= journal_len_q + JL_W'(1);
							left_q <= LEN_W'(cnt_ext);
							dir_q <= 1'b1; first_q <= 1'b1;
							src_q <= text_len_q - TL_W'(cnt_ext);
							dst_q <= TL_W'(erased_len_q);
							text_len_q <= text_len_q - TL_W'(cnt_ext);
							erased_len_q <= erased_len_q + EL_W'(cnt_ext);
						end else if (cmd.opcode == OP_UNDO && st_d == ST_OK) begin
							journal_len_q <= journal_len_q - JL_W'(1);
						end
					end
				end
				BK_READ: res_q.read_byte <= t_rdata;
				BK_JRD: begin
					if (!j_rdata[JE_W-1]) begin
						if (j_rdata[LEN_W-1:0] > LEN_W'(text_len_q)) text_len_q <= '0;
						else text_len_q <= text_len_q - TL_W'(j_rdata[LEN_W-1:0]);
					end else if (un_n != '0) begin
						left_q <= un_n; dir_q <= 1'b0; first_q <= 1'b1;
						src_q <= TL_W'(erased_len_q - EL_W'(un_n));
						dst_q <= text_len_q;
						text_len_q <= text_len_q + TL_W'(un_n);
						erased_len_q <= erased_len_q - EL_W'(un_n);
					end
				end
				BK_MOVE: begin
					// read leads write: each byte is written in the cycle after its read
					first_q <= 1'b0;
					src_q <= src_q + TL_W'(1);
					if (!first_q) dst_q <= dst_q + TL_W'(1);
					if (first_q || left_q != '0) left_q <= left_q - LEN_W'(1);
				end
				BK_DONE: begin
					res_q.text_length <= CNT_W'(text_len_q);
					res_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- hdl/char_stack_with_undo_journal_core.sv -----
// Top level: text buffer with erase stack and undo journal.
// Usage:
//   Input side is a queue: drive the item on in_item and raise push; the item
//   is taken at a clock edge with push high and full low.
//   Result side is a queue: while empty is low, out_item holds the oldest
//   result; raise pop to take it. Every item gives exactly one result.
// Flow:
//   A two-entry command queue feeds an executor that works one item at a time.
//   Append and refused items go straight to the result state; read passes
//   through a text read, undo through a journal read; erase and undo of an
//   erase move their bytes through the memories, a single byte move a cycle.
//   The executor takes the next item only in the cycle after its result is
//   popped.
//   The executor holds while its result register still waits to be popped;
//   the command queue then fills and full stalls the sender.
// Reset:
//   arst_n clears all lengths, the journal depth and open run; memory contents
//   are undefined but never read before written. No clearing pass is needed.
module char_stack_with_undo_journal_core import csu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      push,
	output logic      full,
	output out_item_t out_item,
	output logic      empty,
	input  logic      pop
);
	cmd_t cmd;
	logic cmd_valid, cmd_take, res_valid;

	csu_front u_front (
		.clk, .arst_n, .in_item, .push, .full, .cmd, .cmd_valid, .cmd_take);

	csu_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take,
		.res(out_item), .res_valid, .res_take(pop));

	assign empty = !res_valid;

`ifndef SYNTH
	// hold the result until popped
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("result changed before pop");
	// never start a new command while a result waits
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !cmd_take)
		else $error("command taken while result pending");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_item.status <= 3'd4))
		else $error("bad status code");
`endif
endmodule
